// ===== rtl/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

  localparam logic [5:0] STEP_IDLE = 6'd63;
  localparam logic [7:0] PHASE_TICKS_RESET = 8'd100;

  // Phase numbers within each command's sequence, up to the last phase of each.
  localparam logic [5:0] WR_BIT_STEPS = 6'd24;
  localparam logic [5:0] WR_SDA_FREE  = 6'd25;
  localparam logic [5:0] WR_ACK_STEP  = 6'd26;
  localparam logic [5:0] RD_BIT_STEPS = 6'd16;
  localparam logic [5:0] RD_ACK_DRIVE = 6'd17;
  localparam logic [5:0] RD_ACK_HIGH  = 6'd18;
  localparam logic [5:0] RD_LAST_STEP = 6'd19;
  localparam logic [5:0] ST_LAST_STEP = 6'd2;
  localparam logic [5:0] SP_LAST_STEP = 6'd3;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BUS_BUSY  = 2'd1,
    STAT_BUS_ERROR = 2'd2,
    STAT_NO_ACK    = 2'd3
  } status_t;

  typedef struct packed {
    logic [5:0] step;
    cmd_t       cmd;
    logic [3:0] bit_count;
    logic [7:0] shift;
    logic [7:0] ticks;
    logic       scl;
    logic       sda;
    logic       ack;
    status_t    status;
    logic [7:0] rx;
  } eng_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    status_t    status;
    logic [7:0] rx;
    logic       rejected;
  } eng_result_t;

endpackage

// ===== rtl/i2cmbe_step.sv =====
module i2cmbe_step (
  input  i2cmbe_pkg::eng_state_t  cur,
  input  logic [2:0]              command,
  input  logic                    sda_sample,
  input  logic [7:0]              tx_byte,
  input  logic                    give_ack,
  input  logic [7:0]              phase_ticks,
  output i2cmbe_pkg::eng_state_t  nxt,
  output i2cmbe_pkg::eng_result_t res
);
  import i2cmbe_pkg::*;

  // Sets the lines, and shifts the write byte, for the phase that st.step names.
  function automatic eng_state_t enter_phase(eng_state_t st);
    eng_state_t o;
    logic [4:0] sub;
    o = st;
    // In the bit phases of a write, bit_count always equals step / 3.
    sub = st.step[4:0] - {st.bit_count, 1'b0} - 5'(st.bit_count);
    case (st.cmd)
      CMD_START: begin
        if (st.step == 6'd0) begin
          o.sda = 1'b1;
          o.scl = 1'b1;
        end else begin
          o.sda = 1'b0;
        end
      end
      CMD_WRITE: begin
        if (st.step < WR_BIT_STEPS) begin
          if (sub[1:0] == 2'd0) begin
            o.scl = 1'b0;
          end else if (sub[1:0] == 2'd1) begin
            o.sda   = st.shift[7];
            o.shift = {st.shift[6:0], 1'b0};
          end else begin
            o.scl = 1'b1;
          end
        end else if (st.step == WR_BIT_STEPS) begin
          o.scl = 1'b0;
        end else if (st.step == WR_SDA_FREE) begin
          o.sda = 1'b1;
        end else begin
          o.scl = 1'b1;
        end
      end
      CMD_READ: begin
        if (st.step < RD_BIT_STEPS) begin
          o.scl = st.step[0];
        end else if (st.step == RD_BIT_STEPS) begin
          o.scl = 1'b0;
        end else if (st.step == RD_ACK_DRIVE) begin
          o.sda = !st.ack;
        end else if (st.step == RD_ACK_HIGH) begin
          o.scl = 1'b1;
        end else begin
          o.scl = 1'b0;
        end
      end
      default: begin
        if (st.step == 6'd0) begin
          o.scl = 1'b0;
        end else if (st.step == 6'd1) begin
          o.sda = 1'b0;
        end else if (st.step == 6'd2) begin
          o.scl = 1'b1;
        end else begin
          o.sda = 1'b1;
        end
      end
    endcase
    return o;
  endfunction

  logic [7:0] limit;
  logic [7:0] ticks_inc;
  logic [4:0] wr_sub;
  logic       fin;
  logic       rej;
  logic       done;
  eng_state_t st_a;

  assign limit     = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign ticks_inc = cur.ticks + 8'd1;
  assign wr_sub    = cur.step[4:0] - {cur.bit_count, 1'b0} - 5'(cur.bit_count);

  always_comb begin
    nxt  = cur;
    st_a = cur;
    rej  = 1'b0;
    done = 1'b0;
    fin  = 1'b0;
    if (command > 3'(CMD_STOP)) begin
      rej = 1'b1;
    end else if (cur.step == STEP_IDLE) begin
      if (command != 3'(CMD_TICK)) begin
        st_a.cmd       = cmd_t'(command);
        st_a.step      = 6'd0;
        st_a.ticks     = 8'd0;
        st_a.bit_count = 4'd0;
        st_a.status    = STAT_OK;
        if (command == 3'(CMD_WRITE)) begin
          st_a.shift = tx_byte;
        end
        if (command == 3'(CMD_READ)) begin
          st_a.ack   = give_ack;
          st_a.shift = 8'd0;
          st_a.sda   = 1'b1;
        end
        nxt = enter_phase(st_a);
      end
    end else if (command != 3'(CMD_TICK)) begin
      rej = 1'b1;
    end else if (ticks_inc < limit) begin
      nxt.ticks = ticks_inc;
    end else begin
      st_a.ticks = 8'd0;
      case (cur.cmd)
        CMD_START: begin
          if (cur.step == 6'd0 && !sda_sample) begin
            st_a.status = STAT_BUS_BUSY;
            fin = 1'b1;
          end else if (cur.step == 6'd1 && sda_sample) begin
            st_a.status = STAT_BUS_ERROR;
            fin = 1'b1;
          end else if (cur.step >= ST_LAST_STEP) begin
            fin = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (cur.step < WR_BIT_STEPS && wr_sub[1:0] == 2'd2) begin
            st_a.bit_count = cur.bit_count + 4'd1;
          end
          if (cur.step >= WR_ACK_STEP) begin
            if (sda_sample) begin
              st_a.status = STAT_NO_ACK;
            end
            st_a.scl = 1'b0;
            fin = 1'b1;
          end
        end
        CMD_READ: begin
          if (cur.step < RD_BIT_STEPS && cur.step[0]) begin
            st_a.shift     = {cur.shift[6:0], sda_sample};
            st_a.bit_count = cur.bit_count + 4'd1;
          end
          if (cur.step >= RD_LAST_STEP) begin
            st_a.rx = st_a.shift;
            fin = 1'b1;
          end
        end
        default: begin
          if (cur.step >= SP_LAST_STEP) begin
            fin = 1'b1;
          end
        end
      endcase
      if (fin) begin
        st_a.step = STEP_IDLE;
        nxt  = st_a;
        done = 1'b1;
      end else begin
        st_a.step = cur.step + 6'd1;
        nxt = enter_phase(st_a);
      end
    end
  end

  always_comb begin
    res.scl      = nxt.scl;
    res.sda      = nxt.sda;
    res.busy     = (nxt.step != STEP_IDLE);
    res.done     = done;
    res.status   = nxt.status;
    res.rx       = nxt.rx;
    res.rejected = rej;
  end

endmodule

// ===== rtl/i2c_master_byte_engine_core.sv =====
// The result of an item is registered and on the output in the cycle after its transfer.
// Throughput: one item per cycle while out_ready is high; the sequencer state advances in a single
// combinational step between the state register and the result register.
// Reset (rst, synchronous): sequencer idle with both lines released, status ok and received byte
// zero in its state, phase length 100 ticks, no result pending; the result register is not reset.
module i2c_master_byte_engine_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] command,
  input  logic       sda_sample,
  input  logic [7:0] tx_byte,
  input  logic       give_ack,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_release,
  output logic       sda_release,
  output logic       busy_res,
  output logic       done_res,
  output logic [1:0] status,
  output logic [7:0] rx_byte,
  output logic       rejected
);
  import i2cmbe_pkg::*;

  logic [7:0]  phase_ticks;
  eng_state_t  state;
  eng_state_t  state_next;
  eng_result_t res_next;
  eng_result_t res;
  logic        take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign take      = in_valid && in_ready;

  i2cmbe_step u_step (
    .cur        (state),
    .command    (command),
    .sda_sample (sda_sample),
    .tx_byte    (tx_byte),
    .give_ack   (give_ack),
    .phase_ticks(phase_ticks),
    .nxt        (state_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.step      <= STEP_IDLE;
      state.cmd       <= CMD_TICK;
      state.bit_count <= 4'd0;
      state.shift     <= 8'd0;
      state.ticks     <= 8'd0;
      state.scl       <= 1'b1;
      state.sda       <= 1'b1;
      state.ack       <= 1'b0;
      state.status    <= STAT_OK;
      state.rx        <= 8'd0;
    end else if (take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The result register loads on every input transfer.
  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign scl_release = res.scl;
  assign sda_release = res.sda;
  assign busy_res    = res.busy;
  assign done_res    = res.done;
  assign status      = res.status;
  assign rx_byte     = res.rx;
  assign rejected    = res.rejected;

endmodule
